// ----- hdl/tlfs_pkg.sv -----
// Shared types and constants for the two-level feedback scheduler.
// Depends on nothing; every other file in hdl/ imports it.
`default_nettype none

package tlfs_pkg;

   localparam int TASK_W     = 4;   // task id field
   localparam int BURST_IN_W = 8;   // burst field on the request word
   localparam int STAMP_W    = 16;  // tick counter, stamps, turnaround
   localparam int SLICE_W    = 4;   // time_slice register
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SLICE_W-1:0] SLICE_RESET = 4'd2;

   // register index, taken from the word address bit of paddr
   localparam logic REG_TIME_SLICE = 1'b0;

   typedef enum logic [1:0] {
      EV_IDLE   = 2'd0,
      EV_RAN    = 2'd1,
      EV_DEMOTE = 2'd2,
      EV_DONE   = 2'd3
   } tick_event_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_sts_type;

   typedef struct packed {
      logic                  arrive_valid;
      logic [TASK_W-1:0]     arrive_task;
      logic [BURST_IN_W-1:0] arrive_burst;
   } request_type;

   typedef struct packed {
      logic               run_valid;
      logic [TASK_W-1:0]  run_task;
      logic               run_level;
      tick_event_type     tick_event;
      logic [STAMP_W-1:0] turnaround;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/tlfs_fifo.sv -----
// Circular queue of task ids with same-cycle push and pop.
// Depends on tlfs_pkg for the id width and the control/status structs.
`default_nettype none

module tlfs_fifo
   import tlfs_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter bit PUSH_FIRST = 1'b1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fifo_ctl_type      ctl,
   input  wire logic [TASK_W-1:0] push_id,
   output fifo_sts_type           sts,
   output logic [TASK_W-1:0]      head_id
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
   localparam logic [PTR_W:0]   SUM_WRAP  = (PTR_W+1)'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);

   logic [TASK_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_ok;
   logic [PTR_W:0]    tail_sum;
   logic [PTR_W-1:0]  tail_ptr;

   always_comb begin
      sts.empty = (count_ff == '0);
      sts.full  = (count_ff == CNT_FULL);
      // a pop ahead of the push frees a slot; a push ahead of the pop does not
      push_ok   = ctl.push && (!sts.full || (ctl.pop && !PUSH_FIRST));
      // push-first queue, empty with a push this cycle: hand the new id straight out
      head_id   = (PUSH_FIRST && sts.empty) ? push_id : mem[head_ff];
      tail_sum  = {1'b0, head_ff} + (PTR_W+1)'(count_ff);
      tail_ptr  = (tail_sum >= SUM_WRAP) ? PTR_W'(tail_sum - SUM_WRAP) : PTR_W'(tail_sum);
      head_in   = head_ff;
      if (ctl.pop) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
      end
      count_in  = count_ff + CNT_W'(push_ok) - CNT_W'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[tail_ptr] <= push_id;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("fifo count beyond depth");
   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      ctl.pop && sts.empty |-> push_ok)
      else $error("fifo popped while empty with no push");
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      sts.full && ctl.push && !ctl.pop |=> count_ff == CNT_FULL)
      else $error("fifo overflowed");
`endif

endmodule

`default_nettype wire

// ----- hdl/tlfs_csr.sv -----
// APB-style register file holding the time_slice register.
// Depends on tlfs_pkg for widths, the register index and the reset value.
`default_nettype none

module tlfs_csr
   import tlfs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [SLICE_W-1:0]    time_slice
);

   logic [SLICE_W-1:0] time_slice_ff, time_slice_in;
   logic               wr_en;

   always_comb begin
      pready        = 1'b1;
      wr_en         = psel && penable && pwrite && pready;
      time_slice_in = time_slice_ff;
      if (wr_en && (paddr[2] == REG_TIME_SLICE)) begin
         time_slice_in = pwdata[SLICE_W-1:0];
      end
      prdata = '0;
      if (paddr[2] == REG_TIME_SLICE) begin
         prdata = CSR_DATA_W'(time_slice_ff);
      end
      time_slice = time_slice_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_slice_ff <= SLICE_RESET;
      end else begin
         time_slice_ff <= time_slice_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tlfs_core.sv -----
// Scheduler state and the single-tick update: arrival, dispatch, run, retire.
// Depends on tlfs_pkg and tlfs_fifo (one queue per level).
`default_nettype none

module tlfs_core
   import tlfs_pkg::*;
#(
   parameter int TASKS      = 16,
   parameter int BURST_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire request_type        req,
   input  wire logic [SLICE_W-1:0] time_slice,
   output result_type              result
);

   localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CMP_W = (TASK_W > IDX_W + 1) ? TASK_W : IDX_W + 1;

   logic [BURST_BITS-1:0] burst_left_ff [TASKS];
   logic [STAMP_W-1:0]    stamp_ff      [TASKS];

   logic                  busy_ff, busy_in;
   logic [TASK_W-1:0]     cur_task_ff, cur_task_in;
   logic                  cur_level_ff, cur_level_in;
   logic [SLICE_W-1:0]    slice_ff, slice_in;
   logic [STAMP_W-1:0]    tick_ff, tick_in;

   fifo_ctl_type          high_ctl, low_ctl;
   fifo_sts_type          high_sts, low_sts;
   logic [TASK_W-1:0]     high_head, low_head;

   logic [BURST_BITS-1:0] burst_new, burst_cur;
   logic [STAMP_W-1:0]    stamp_cur;
   logic                  arrive, high_avail, disp_high, disp_low, busy_now;
   logic                  fwd, done, demote;
   logic [TASK_W-1:0]     run_id;
   logic                  run_level;
   logic [IDX_W-1:0]      run_idx, arr_idx;
   logic [SLICE_W-1:0]    slice_cur, slice_dec;

   tlfs_fifo #(.DEPTH(TASKS), .PUSH_FIRST(1'b1)) u_high_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (high_ctl),
      .push_id (req.arrive_task),
      .sts     (high_sts),
      .head_id (high_head)
   );

   tlfs_fifo #(.DEPTH(TASKS), .PUSH_FIRST(1'b0)) u_low_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (low_ctl),
      .push_id (run_id),
      .sts     (low_sts),
      .head_id (low_head)
   );

   always_comb begin
      burst_new  = BURST_BITS'(req.arrive_burst);
      arrive     = req.arrive_valid && (burst_new != '0) &&
                   (CMP_W'(req.arrive_task) < CMP_W'(TASKS));
      arr_idx    = IDX_W'(req.arrive_task);

      // the arrival lands in the high queue before dispatch looks at it
      high_avail = !high_sts.empty || arrive;
      disp_high  = !busy_ff && high_avail;
      disp_low   = !busy_ff && !high_avail && !low_sts.empty;
      busy_now   = busy_ff || disp_high || disp_low;

      run_id     = disp_high ? high_head : (disp_low ? low_head : cur_task_ff);
      run_level  = disp_high ? 1'b0 : (disp_low ? 1'b1 : cur_level_ff);
      run_idx    = IDX_W'(run_id);

      slice_cur  = slice_ff;
      if (disp_high || disp_low) begin
         slice_cur = (time_slice == '0) ? SLICE_W'(1) : time_slice;
      end
      slice_dec  = (slice_cur != '0) ? slice_cur - SLICE_W'(1) : '0;

      // an arrival of the running task overwrites its burst and stamp first
      fwd        = arrive && (arr_idx == run_idx);
      burst_cur  = fwd ? burst_new : burst_left_ff[run_idx];
      stamp_cur  = fwd ? tick_ff : stamp_ff[run_idx];

      tick_in    = tick_ff + STAMP_W'(1);
      done       = (burst_cur <= BURST_BITS'(1));
      demote     = busy_now && !done && (slice_dec == '0);

      high_ctl.push = step && arrive;
      high_ctl.pop  = step && disp_high;
      low_ctl.pop   = step && disp_low;
      low_ctl.push  = step && demote;

      busy_in      = busy_now && !done && !demote;
      cur_task_in  = run_id;
      cur_level_in = run_level;
      slice_in     = busy_now ? (done ? slice_cur : slice_dec) : slice_ff;

      result.run_valid  = busy_now;
      result.run_task   = busy_now ? run_id : '0;
      result.run_level  = busy_now ? run_level : 1'b0;
      result.turnaround = '0;
      if (!busy_now) begin
         result.tick_event = EV_IDLE;
      end else if (done) begin
         result.tick_event = EV_DONE;
         result.turnaround = tick_in - stamp_cur;
      end else if (demote) begin
         result.tick_event = EV_DEMOTE;
      end else begin
         result.tick_event = EV_RAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cur_task_ff  <= '0;
         cur_level_ff <= 1'b0;
         slice_ff     <= '0;
         tick_ff      <= '0;
      end else if (step) begin
         busy_ff      <= busy_in;
         cur_task_ff  <= cur_task_in;
         cur_level_ff <= cur_level_in;
         slice_ff     <= slice_in;
         tick_ff      <= tick_in;
      end
   end

   // per-task tables; the run update comes last so it wins on a shared index
   always_ff @(posedge clock) begin
      if (step && arrive) begin
         burst_left_ff[arr_idx] <= burst_new;
         stamp_ff[arr_idx]      <= tick_ff;
      end
      if (step && busy_now) begin
         burst_left_ff[run_idx] <= done ? '0 : burst_cur - BURST_BITS'(1);
      end
   end

`ifndef NO_ASSERTIONS
   a_one_dispatch: assert property (@(posedge clock) disable iff (reset)
      !(disp_high && disp_low))
      else $error("dispatch from both levels");
   a_slice_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> slice_ff != '0)
      else $error("running task holds an empty quantum");
   a_demote_low: assert property (@(posedge clock) disable iff (reset)
      step && demote |=> !busy_ff)
      else $error("demoted task still running");
`endif

endmodule

`default_nettype wire

// ----- hdl/two_level_feedback_scheduler.sv -----
// Top level of the two-level feedback scheduler: request/result registers,
// stall handling and the register port. Depends on tlfs_pkg, tlfs_csr, tlfs_core.
`default_nettype none

// Usage
//   Each request word is one scheduler tick, optionally carrying a new task
//   (req_arrive_valid, id, burst). Each tick yields exactly one result word:
//   which task ran, the level it came from, the tick event (idle, ran,
//   demoted, completed) and, on completion, its turnaround in ticks.
//   time_slice sits at byte address 0 of the APB-style port (psel, penable,
//   pwrite, paddr, pwdata, prdata, pready); pready is tied high. Write it only
//   while no tick is in flight.
// Timing
//   An accepted word passes through the request register, then one pass of
//   scheduling logic into the result register. One word per cycle is
//   sustained while rsp_stall does not hold a result; the tick update (queue
//   push/pop, table read-modify-write, counters) is a single combinational pass.
// Reset
//   Synchronous, active high. Both queues and the running task clear, the tick
//   counter goes to 0 and time_slice returns to 2. Queue storage and the
//   per-task tables are not cleared; entries are used only after written.
// Stall
//   When rsp_stall holds a result, the result register holds; a request word
//   already registered waits and req_stall rises until the result drains.

module two_level_feedback_scheduler
   import tlfs_pkg::*;
#(
   parameter int TASKS      = 16,
   parameter int BURST_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_arrive_valid,
   input  wire logic [TASK_W-1:0]     req_arrive_task,
   input  wire logic [BURST_IN_W-1:0] req_arrive_burst,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_run_valid,
   output logic      [TASK_W-1:0]     rsp_run_task,
   output logic                       rsp_run_level,
   output logic      [1:0]            rsp_tick_event,
   output logic      [STAMP_W-1:0]    rsp_turnaround,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic               in_valid_ff, in_valid_in;
   request_type        req_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;
   result_type         result;
   logic               advance, step;
   logic [SLICE_W-1:0] time_slice;

   tlfs_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .time_slice (time_slice)
   );

   tlfs_core #(.TASKS(TASKS), .BURST_BITS(BURST_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .req        (req_ff),
      .time_slice (time_slice),
      .result     (result)
   );

   always_comb begin
      // result register is free, or drains this cycle
      advance      = !rsp_valid_ff || !rsp_stall;
      step         = in_valid_ff && advance;
      // hold off the sender only while a registered word cannot move on
      req_stall    = in_valid_ff && !advance;
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load the request on accept, the result on a tick
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff.arrive_valid <= req_arrive_valid;
         req_ff.arrive_task  <= req_arrive_task;
         req_ff.arrive_burst <= req_arrive_burst;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_valid  = rsp_ff.run_valid;
   assign rsp_run_task   = rsp_ff.run_task;
   assign rsp_run_level  = rsp_ff.run_level;
   assign rsp_tick_event = rsp_ff.tick_event;
   assign rsp_turnaround = rsp_ff.turnaround;

`ifndef NO_ASSERTIONS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled with room downstream");
   a_tick_lands: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("tick result lost");
   a_tat_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.tick_event != EV_DONE) |-> rsp_ff.turnaround == '0)
      else $error("turnaround reported without completion");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.run_valid |->
         (rsp_ff.tick_event == EV_IDLE) && (rsp_ff.run_task == '0))
      else $error("idle tick carries a task");
`endif

endmodule

`default_nettype wire

// ----- bench/two_level_feedback_scheduler_tb.sv -----
// Self-checking bench for two_level_feedback_scheduler: a directed table and random
// tick words, each result compared with an in-bench scheduler prediction.
// Depends on tlfs_pkg and the RTL under hdl/.
module two_level_feedback_scheduler_tb
   import tlfs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASK_COUNT    = 16;
   localparam int BURST_BITS    = 8;
   localparam logic [BURST_IN_W-1:0] BURST_MASK = BURST_IN_W'((1 << BURST_BITS) - 1);
   localparam logic [CSR_ADDR_W-1:0] SLICE_ADDR = {REG_TIME_SLICE, 2'b00};
   localparam int KEEP_SLICE    = -1;    // table row leaves time_slice alone
   localparam int SETTLE_CYCLES = 4;     // result register plus margin
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake before giving up
   localparam int PHASES        = 14;
   localparam int PHASE_WORDS   = 100;
   localparam int PHASE_SLICE [PHASES] = '{2, 15, 0, 1, 3, 15, 4, 1, 8, 0, 5, 2, 7, 15};
   localparam int HOLD_PHASE    = 4;
   localparam int STEADY_PHASE  = 7;     // no idling on either side

   // One directed row: optional time_slice write before it, the tick word, and
   // the result typed in where it is obvious.
   typedef struct packed {
      int                    slice;
      logic                  av;
      logic [TASK_W-1:0]     tid;
      logic [BURST_IN_W-1:0] burst;
      logic                  typed;
      result_type            want;
   } dir_row_type;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic                  req_arrive_valid = 1'b0;
   logic [TASK_W-1:0]     req_arrive_task  = '0;
   logic [BURST_IN_W-1:0] req_arrive_burst = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic                  rsp_run_valid;
   logic [TASK_W-1:0]     rsp_run_task;
   logic                  rsp_run_level;
   logic [1:0]            rsp_tick_event;
   logic [STAMP_W-1:0]    rsp_turnaround;
   logic                  psel             = 1'b0;
   logic                  penable          = 1'b0;
   logic                  pwrite           = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr            = '0;
   logic [CSR_DATA_W-1:0] pwdata           = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   two_level_feedback_scheduler dut (.*);

   // Scheduler prediction state: two round-robin levels, per-task tables, the
   // running task and its quantum, the tick counter and the time_slice copy.
   logic [TASK_W-1:0]     high_level_q [$];
   logic [TASK_W-1:0]     low_level_q [$];
   logic [BURST_IN_W-1:0] task_burst [TASK_COUNT] = '{default: '0};
   logic [STAMP_W-1:0]    task_stamp [TASK_COUNT] = '{default: '0};
   logic [TASK_W-1:0]     run_id       = '0;
   logic                  run_lvl      = 1'b0;
   logic                  running      = 1'b0;
   logic [SLICE_W-1:0]    quantum_left = '0;
   logic [STAMP_W-1:0]    ticks        = '0;
   logic [SLICE_W-1:0]    slice_reg    = SLICE_RESET;

   result_type tick_results_due [$];   // one expected result per accepted word

   int idle_pct        = 30;   // sender gap chance per cycle
   int stall_pct       = 30;   // receiver stall chance per cycle
   int hold_asked      = 0;    // bumped by the sender to ask for a hold-off
   int hold_seen       = 0;
   int hold_left       = 0;
   int quiet           = 0;
   int words_sent      = 0;
   int results_checked = 0;
   int completions     = 0;
   int demotions       = 0;
   int slice_writes    = 0;
   int mismatches      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the predicted scheduler by one tick and return the result word.
   function automatic result_type schedule_tick(input logic av, input logic [TASK_W-1:0] tid,
                                                input logic [BURST_IN_W-1:0] burst);
      result_type            r;
      logic [BURST_IN_W-1:0] b;
      r = '0;
      b = burst & BURST_MASK;
      // Admit the arrival into the high level; a full level drops it.
      if (av && b != 0 && tid < TASK_COUNT) begin
         task_burst[tid] = b;
         task_stamp[tid] = ticks;
         if (high_level_q.size() < TASK_COUNT) high_level_q.push_back(tid);
      end
      // Dispatch when idle, high level first, with a fresh quantum.
      if (!running) begin
         if (high_level_q.size() != 0) begin
            run_id  = high_level_q.pop_front();
            run_lvl = 1'b0;
            running = 1'b1;
         end else if (low_level_q.size() != 0) begin
            run_id  = low_level_q.pop_front();
            run_lvl = 1'b1;
            running = 1'b1;
         end
         if (running) quantum_left = (slice_reg != 0) ? slice_reg : SLICE_W'(1);
      end
      ticks = ticks + 1'b1;
      if (running) begin
         r.run_valid = 1'b1;
         r.run_task  = run_id;
         r.run_level = run_lvl;
         // A stale copy has no burst left and completes at once.
         if (task_burst[run_id] <= 1) begin
            task_burst[run_id] = '0;
            r.tick_event       = EV_DONE;
            r.turnaround       = ticks - task_stamp[run_id];
            running            = 1'b0;
         end else begin
            task_burst[run_id] = task_burst[run_id] - 1'b1;
            if (quantum_left != 0) quantum_left = quantum_left - 1'b1;
            if (quantum_left == 0) begin
               r.tick_event = EV_DEMOTE;
               if (low_level_q.size() < TASK_COUNT) low_level_q.push_back(run_id);
               running = 1'b0;
            end else begin
               r.tick_event = EV_RAN;
            end
         end
      end
      return r;
   endfunction

   // Table row checked against the prediction.
   function automatic dir_row_type step(input int sl, input logic av,
                                        input logic [TASK_W-1:0] tid,
                                        input logic [BURST_IN_W-1:0] burst);
      dir_row_type d;
      d       = '0;
      d.slice = sl;
      d.av    = av;
      d.tid   = tid;
      d.burst = burst;
      return d;
   endfunction

   // Table row with its result typed in.
   function automatic dir_row_type known(input int sl, input logic av,
                                         input logic [TASK_W-1:0] tid,
                                         input logic [BURST_IN_W-1:0] burst,
                                         input logic rv, input logic [TASK_W-1:0] rt,
                                         input logic rl, input tick_event_type ev,
                                         input logic [STAMP_W-1:0] tat);
      dir_row_type d;
      d                 = step(sl, av, tid, burst);
      d.typed           = 1'b1;
      d.want.run_valid  = rv;
      d.want.run_task   = rt;
      d.want.run_level  = rl;
      d.want.tick_event = ev;
      d.want.turnaround = tat;
      return d;
   endfunction

   // Offer one tick word, hold it until accepted, then record its result.
   task automatic send_word(input logic av, input logic [TASK_W-1:0] tid,
                            input logic [BURST_IN_W-1:0] burst,
                            input logic typed, input result_type want);
      result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_arrive_valid <= av;
      req_arrive_task  <= tid;
      req_arrive_burst <= burst;
      do @(posedge clock); while (req_stall);
      predicted = schedule_tick(av, tid, burst);
      tick_results_due.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   // Drop valid and wait until every result has drained.
   task automatic settle();
      req_valid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Read time_slice back and compare with the expected value.
   task automatic csr_check(input logic [SLICE_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= SLICE_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(want)) begin
         $error("time_slice readback: expected %0d, actual %0d", want, prdata);
         mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write time_slice (setup, then access) and read it back.
   task automatic write_slice(input logic [SLICE_W-1:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SLICE_ADDR;
      pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      slice_reg  = v;
      slice_writes++;
      @(posedge clock);
      csr_check(v);
   endtask

   // Compare one result word with the oldest expectation, field by field.
   task automatic check_result();
      result_type want;
      if (tick_results_due.size() == 0) begin
         $error("result word with no tick pending: task %0d event %0d",
                rsp_run_task, rsp_tick_event);
         mismatches++;
      end else begin
         want = tick_results_due.pop_front();
         results_checked++;
         if (rsp_run_valid !== want.run_valid) begin
            $error("run_valid: expected %0d, actual %0d", want.run_valid, rsp_run_valid);
            mismatches++;
         end
         if (rsp_run_task !== want.run_task) begin
            $error("run_task: expected %0d, actual %0d", want.run_task, rsp_run_task);
            mismatches++;
         end
         if (rsp_run_level !== want.run_level) begin
            $error("run_level: expected %0d, actual %0d", want.run_level, rsp_run_level);
            mismatches++;
         end
         if (rsp_tick_event !== want.tick_event) begin
            $error("tick_event: expected %0d, actual %0d", want.tick_event, rsp_tick_event);
            mismatches++;
         end
         if (rsp_turnaround !== want.turnaround) begin
            $error("turnaround: expected %0d, actual %0d", want.turnaround, rsp_turnaround);
            mismatches++;
         end
         if (want.tick_event == EV_DONE) completions++;
         if (want.tick_event == EV_DEMOTE) demotions++;
      end
   endtask

   // Result side: check every accepted word, then pick the stall for the next
   // cycle. A hold-off request from the sender is counted down here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Watchdog: count cycles with no handshake anywhere and bail out when stuck.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      dir_row_type           plan [$];
      logic                  av;
      logic [TASK_W-1:0]     tid;
      logic [BURST_IN_W-1:0] burst;
      int                    arrive_pct;
      int                    r;

      // Directed table. The typed rows walk task 0 through two demotions and task 3
      // through a redelivery of an active task and the stale copy it leaves behind.
      plan = '{
         known(KEEP_SLICE, 1'b0,  0,   0, 1'b0,  0, 1'b0, EV_IDLE,   0), // empty tick
         known(KEEP_SLICE, 1'b1, 15,   0, 1'b0,  0, 1'b0, EV_IDLE,   0), // zero burst
         known(KEEP_SLICE, 1'b0,  5,   9, 1'b0,  0, 1'b0, EV_IDLE,   0), // valid low
         known(KEEP_SLICE, 1'b1, 15,   1, 1'b1, 15, 1'b0, EV_DONE,   1), // one-tick task
         known(KEEP_SLICE, 1'b1,  0, 255, 1'b1,  0, 1'b0, EV_RAN,    0), // longest burst
         known(KEEP_SLICE, 1'b0,  0,   0, 1'b1,  0, 1'b0, EV_DEMOTE, 0),
         known(KEEP_SLICE, 1'b0,  0,   0, 1'b1,  0, 1'b1, EV_RAN,    0), // from low level
         known(KEEP_SLICE, 1'b1,  3,   2, 1'b1,  0, 1'b1, EV_DEMOTE, 0),
         known(KEEP_SLICE, 1'b0,  0,   0, 1'b1,  3, 1'b0, EV_RAN,    0),
         known(KEEP_SLICE, 1'b1,  3,   1, 1'b1,  3, 1'b0, EV_DONE,   1), // active task again
         known(KEEP_SLICE, 1'b0,  0,   0, 1'b1,  3, 1'b0, EV_DONE,   2), // stale copy
         known(KEEP_SLICE, 1'b0,  0,   0, 1'b1,  0, 1'b1, EV_RAN,    0),
         step(0,          1'b1,  7,   3),  // zero slice acts as one
         step(KEEP_SLICE, 1'b1,  8,   2),
         step(KEEP_SLICE, 1'b0, 10, 170),
         step(KEEP_SLICE, 1'b0,  0,   0),
         step(KEEP_SLICE, 1'b0,  0,   0),
         step(15,         1'b1,  9, 200),  // widest slice
         step(KEEP_SLICE, 1'b1, 10,  20),
         step(KEEP_SLICE, 1'b1,  9,   5),
         step(KEEP_SLICE, 1'b1,  6, 170),
         step(1,          1'b1, 12,  85),
         step(KEEP_SLICE, 1'b1, 13, 255),
         step(KEEP_SLICE, 1'b0,  5,  85),
         step(2,          1'b0,  0,   0)   // back to the reset slice
      };

      // Hold reset, then check the reset slice value.
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(SLICE_RESET);

      foreach (plan[i]) begin
         if (plan[i].slice != KEEP_SLICE) begin
            settle();
            write_slice(plan[i].slice[SLICE_W-1:0]);
         end
         send_word(plan[i].av, plan[i].tid, plan[i].burst, plan[i].typed, plan[i].want);
      end

      // Random phases: drain, set the slice, then a run of words whose arrival
      // rate and burst mix decide how deep the levels get.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_slice(PHASE_SLICE[p][SLICE_W-1:0]);
         idle_pct  = (p == STEADY_PHASE) ? 0 : 30;
         stall_pct = (p == STEADY_PHASE) ? 0 : 30;
         case ($urandom_range(3))
            0: arrive_pct = 10;
            1: arrive_pct = 35;
            2: arrive_pct = 60;
            default: arrive_pct = 95;
         endcase
         if (p == HOLD_PHASE) arrive_pct = 95;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Stall the result side for a long stretch and keep offering words.
            if (p == HOLD_PHASE && n == 5) hold_asked++;
            av  = ($urandom_range(99) < arrive_pct);
            tid = TASK_W'($urandom_range(TASK_COUNT - 1));
            // Prefer an idle task id; leave some redeliveries of active ones.
            if ($urandom_range(9) < 8) begin
               for (int k = 0; k < 4 && task_burst[tid] != 0; k++)
                  tid = TASK_W'($urandom_range(TASK_COUNT - 1));
            end
            r = $urandom_range(99);
            if (r < 3) begin
               burst = '0;
            end else if (r < 60) begin
               burst = BURST_IN_W'($urandom_range(6, 1));
            end else if (r < 90) begin
               burst = BURST_IN_W'($urandom_range(30, 1));
            end else begin
               burst = BURST_IN_W'($urandom_range(255, 1));
            end
            send_word(av, tid, burst, 1'b0, '0);
         end
      end

      settle();
      $display("summary: %0d tick words, %0d results checked, %0d completions, %0d demotions",
               words_sent, results_checked, completions, demotions);
      $display("summary: %0d time_slice writes, %0d mismatches", slice_writes, mismatches);
      if (mismatches == 0 && tick_results_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
